// ----- hdl/svr_pkg.sv -----
// shared widths, constants and codes of the servo ramp and pwm duty block
// no dependencies
package svr_pkg;

	localparam int ANGLE_W   = 8;
	localparam int PULSE_W   = 16;
	localparam int FREQ_W    = 16;
	localparam int BITS_W    = 5;
	localparam int DELAY_W   = 16;
	localparam int DUTY_W    = 20;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// serial arithmetic datapath
	localparam int PROD_W = 52;   // widest product: pulse * freq * full
	localparam int MB_W   = 20;   // serial multiplier operand
	localparam int DVS_W  = 20;   // divisor

	localparam logic [DVS_W-1:0]  PWM_SCALE     = 20'd1000000;
	localparam logic [BITS_W-1:0] DUTY_BITS_MAX = 5'd20;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_BITS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_FREQ  = 2'd3;

	// request codes
	localparam logic CMD_MOVE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// result status codes
	localparam logic STATUS_MOVING  = 1'b0;
	localparam logic STATUS_REACHED = 1'b1;

endpackage

// ----- hdl/svr_mul.sv -----
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on svr_pkg
module svr_mul
	import svr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] a,
	input  logic [MB_W-1:0]   b,
	output logic              done,
	output logic [PROD_W-1:0] p
);

	localparam int CNT_W = $clog2(MB_W + 1);

	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] a_q;
	logic [MB_W-1:0]   b_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(MB_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - CNT_W'(1);
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (cnt_q != '0) begin
			if (b_q[0])
				acc_q <= acc_q + a_q;
			a_q <= {a_q[PROD_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[MB_W-1:1]};
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

// ----- hdl/svr_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
// depends on svr_pkg
module svr_div
	import svr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [DVS_W-1:0]  divisor,
	output logic              done,
	output logic [PROD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(PROD_W + 1);

	logic [PROD_W-1:0] quo_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [DVS_W:0]    trial;
	logic              fits;
	logic [DVS_W:0]    rem_next;

	always_comb begin
		trial    = {rem_q, quo_q[PROD_W-1]};
		fits     = (trial >= {1'b0, dvs_q});
		rem_next = fits ? (trial - {1'b0, dvs_q}) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(PROD_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - CNT_W'(1);
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[PROD_W-2:0], fits};
			rem_q <= rem_next[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- hdl/svr_duty.sv -----
// duty sequencer: angle to pulse width to saturated pwm duty count
// depends on svr_pkg, svr_mul, svr_div
module svr_duty
	import svr_pkg::*;
#(
	parameter int unsigned MAX_ANGLE = 180
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [ANGLE_W-1:0] angle,
	input  logic [PULSE_W-1:0] min_pulse,
	input  logic [PULSE_W-1:0] max_pulse,
	input  logic [BITS_W-1:0]  duty_bits,
	input  logic [FREQ_W-1:0]  pwm_freq,
	output logic               done,
	output logic [DUTY_W-1:0]  duty
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_SPAN,
		S_DIV_ANGLE,
		S_MUL_FREQ,
		S_MUL_FULL,
		S_DIV_SCALE
	} state_t;

	state_t            state_q;
	logic              down_q;
	logic              mul_start_q;
	logic [PROD_W-1:0] mul_a_q;
	logic [MB_W-1:0]   mul_b_q;
	logic              div_start_q;
	logic [PROD_W-1:0] div_n_q;
	logic [DVS_W-1:0]  div_d_q;
	logic              done_q;
	logic [DUTY_W-1:0] duty_q;

	logic              mul_done;
	logic [PROD_W-1:0] mul_p;
	logic              div_done;
	logic [PROD_W-1:0] div_q;

	logic [BITS_W-1:0]  bits_eff;
	logic [DUTY_W-1:0]  full;
	logic [PULSE_W-1:0] span;
	logic [PULSE_W-1:0] pulse;

	always_comb begin
		bits_eff = (duty_bits > DUTY_BITS_MAX) ? DUTY_BITS_MAX : duty_bits;
		full     = ~({DUTY_W{1'b1}} << bits_eff);
		span     = (max_pulse >= min_pulse) ? (max_pulse - min_pulse) : (min_pulse - max_pulse);
		// quotient never exceeds the span, so it fits the pulse width
		pulse    = down_q ? (min_pulse - div_q[PULSE_W-1:0])
		                  : (min_pulse + div_q[PULSE_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			done_q      <= 1'b0;
			down_q      <= 1'b0;
			mul_a_q     <= '0;
			mul_b_q     <= '0;
			div_n_q     <= '0;
			div_d_q     <= '0;
			duty_q      <= '0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			done_q      <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						down_q      <= (max_pulse < min_pulse);
						mul_a_q     <= PROD_W'(span);
						mul_b_q     <= MB_W'(angle);
						mul_start_q <= 1'b1;
						state_q     <= S_MUL_SPAN;
					end
				end
				S_MUL_SPAN: begin
					if (mul_done) begin
						div_n_q     <= mul_p;
						div_d_q     <= DVS_W'(MAX_ANGLE);
						div_start_q <= 1'b1;
						state_q     <= S_DIV_ANGLE;
					end
				end
				S_DIV_ANGLE: begin
					if (div_done) begin
						mul_a_q     <= PROD_W'(pulse);
						mul_b_q     <= MB_W'(pwm_freq);
						mul_start_q <= 1'b1;
						state_q     <= S_MUL_FREQ;
					end
				end
				S_MUL_FREQ: begin
					if (mul_done) begin
						mul_a_q     <= mul_p;
						mul_b_q     <= full;
						mul_start_q <= 1'b1;
						state_q     <= S_MUL_FULL;
					end
				end
				S_MUL_FULL: begin
					if (mul_done) begin
						div_n_q     <= mul_p;
						div_d_q     <= PWM_SCALE;
						div_start_q <= 1'b1;
						state_q     <= S_DIV_SCALE;
					end
				end
				S_DIV_SCALE: begin
					if (div_done) begin
						duty_q  <= (div_q > PROD_W'(full)) ? full : div_q[DUTY_W-1:0];
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	svr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.p      (mul_p)
	);

	svr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_n_q),
		.divisor  (div_d_q),
		.done     (div_done),
		.quotient (div_q)
	);

	assign done = done_q;
	assign duty = duty_q;

endmodule

// ----- hdl/servo_angle_ramp_pwm.sv -----
// servo slew-rate limiter with pwm duty output, top level
// depends on svr_pkg and svr_duty (which holds svr_mul and svr_div)
//
// Takes move requests and one-millisecond tick requests. A move while idle is
// evaluated at once; a move while moving replaces the stored target, step,
// tolerance and delay without touching the running countdown. A tick while
// moving counts down, and at zero the stored move is evaluated again. Each
// evaluation gives one result: reached (angle within tolerance, block goes
// idle) or moving (angle stepped toward the goal, clamped to 0..MAX_ANGLE,
// countdown reloaded, zero delay counting as one tick), always with the duty
// count of the current angle. A request with no result keeps the block ready,
// so idle ticks and countdown ticks stream at one per cycle. A request that
// is evaluated stalls requests until its result is loaded, longer while the
// previous result still sits in the output register: the duty is formed by a
// bit-serial multiplier (three runs of 20 steps: span times angle, pulse
// times frequency, times full scale) and a bit-serial restoring divider (two
// runs of 52 steps: by MAX_ANGLE and by one million), plus start and hand-off
// cycles between the runs. A finished result sits in the output register
// while new requests are taken; the next result waits for that register to
// drain. Configuration is to be written through cfg_we/cfg_index/cfg_data
// while the block is idle; the block itself does not enforce this.
module servo_angle_ramp_pwm
	import svr_pkg::*;
#(
	parameter int unsigned MAX_ANGLE = 180
) (
	input  logic                 clk,
	input  logic                 arst_n,

	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,

	// request channel
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  logic                 command,
	input  logic [ANGLE_W-1:0]   aim_angle,
	input  logic [ANGLE_W-1:0]   step_size,
	input  logic [ANGLE_W-1:0]   tolerance,
	input  logic [DELAY_W-1:0]   delay_ms,

	// result channel
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic                 status,
	output logic [ANGLE_W-1:0]   angle_now,
	output logic [ANGLE_W-1:0]   angle_goal,
	output logic [DUTY_W-1:0]    duty
);

	localparam logic [ANGLE_W-1:0] ANGLE_TOP = ANGLE_W'(MAX_ANGLE);

	typedef enum logic [1:0] {
		ST_IDLE,   // taking requests
		ST_DUTY,   // duty chain running
		ST_LOAD    // waiting for the output register
	} state_t;

	// configuration registers
	logic [PULSE_W-1:0] min_pulse_q;
	logic [PULSE_W-1:0] max_pulse_q;
	logic [BITS_W-1:0]  duty_bits_q;
	logic [FREQ_W-1:0]  pwm_freq_q;

	// servo state
	state_t             state_q;
	logic [ANGLE_W-1:0] cur_q;
	logic [ANGLE_W-1:0] goal_q;
	logic [ANGLE_W-1:0] step_q;
	logic [ANGLE_W-1:0] tol_q;
	logic [DELAY_W-1:0] delay_q;
	logic [DELAY_W-1:0] cnt_q;
	logic               moving_q;
	logic               status_q;
	logic               duty_start_q;

	// output register
	logic               res_valid_q;
	logic               res_status_q;
	logic [ANGLE_W-1:0] res_now_q;
	logic [ANGLE_W-1:0] res_goal_q;
	logic [DUTY_W-1:0]  res_duty_q;

	logic               duty_done;
	logic [DUTY_W-1:0]  duty_val;

	// evaluation terms
	logic               cmd_accept;
	logic               out_free;
	logic [ANGLE_W-1:0] ev_goal;
	logic [ANGLE_W-1:0] ev_step;
	logic [ANGLE_W-1:0] ev_tol;
	logic [DELAY_W-1:0] ev_delay;
	logic [DELAY_W-1:0] nx_cnt;
	logic               do_eval;
	logic [ANGLE_W-1:0] ang_err;
	logic               reached;
	logic [ANGLE_W:0]   up_sum;
	logic [ANGLE_W-1:0] dn_angle;
	logic [ANGLE_W-1:0] next_angle;
	logic [DELAY_W-1:0] reload;

	assign cmd_stall  = (state_q != ST_IDLE);
	assign cmd_accept = cmd_valid && !cmd_stall;
	assign out_free   = !res_valid_q || !res_stall;

	always_comb begin
		ev_goal  = goal_q;
		ev_step  = step_q;
		ev_tol   = tol_q;
		ev_delay = delay_q;
		nx_cnt   = cnt_q;
		if (command == CMD_MOVE) begin
			// targets past the end stop are clamped
			ev_goal  = (aim_angle > ANGLE_TOP) ? ANGLE_TOP : aim_angle;
			ev_step  = step_size;
			ev_tol   = tolerance;
			ev_delay = delay_ms;
			do_eval  = !moving_q;
		end else begin
			if (cnt_q != '0)
				nx_cnt = cnt_q - DELAY_W'(1);
			do_eval = moving_q && (nx_cnt == '0);
		end

		ang_err  = (ev_goal >= cur_q) ? (ev_goal - cur_q) : (cur_q - ev_goal);
		reached  = (ang_err <= ev_tol);
		up_sum   = {1'b0, cur_q} + {1'b0, ev_step};
		dn_angle = (cur_q >= ev_step) ? (cur_q - ev_step) : '0;
		if (ev_goal > cur_q)
			next_angle = (up_sum > {1'b0, ANGLE_TOP}) ? ANGLE_TOP : up_sum[ANGLE_W-1:0];
		else
			next_angle = dn_angle;
		// zero delay counts as one tick
		reload = (ev_delay == '0) ? DELAY_W'(1) : ev_delay;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q <= PULSE_W'(500);
			max_pulse_q <= PULSE_W'(2500);
			duty_bits_q <= BITS_W'(14);
			pwm_freq_q  <= FREQ_W'(50);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_PULSE: min_pulse_q <= cfg_data;
				REG_MAX_PULSE: max_pulse_q <= cfg_data;
				REG_DUTY_BITS: duty_bits_q <= cfg_data[BITS_W-1:0];
				REG_PWM_FREQ:  pwm_freq_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// request handling, servo state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cur_q        <= '0;
			goal_q       <= '0;
			step_q       <= '0;
			tol_q        <= '0;
			delay_q      <= '0;
			cnt_q        <= '0;
			moving_q     <= 1'b0;
			status_q     <= STATUS_MOVING;
			duty_start_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			duty_start_q <= 1'b0;
			if (res_valid_q && !res_stall)
				res_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_accept) begin
						if (command == CMD_MOVE) begin
							goal_q  <= ev_goal;
							step_q  <= ev_step;
							tol_q   <= ev_tol;
							delay_q <= ev_delay;
						end else begin
							cnt_q <= nx_cnt;
						end
						if (do_eval) begin
							if (reached) begin
								moving_q <= 1'b0;
								status_q <= STATUS_REACHED;
							end else begin
								cur_q    <= next_angle;
								cnt_q    <= reload;
								moving_q <= 1'b1;
								status_q <= STATUS_MOVING;
							end
							// duty chain sees the updated angle next cycle
							duty_start_q <= 1'b1;
							state_q      <= ST_DUTY;
						end
					end
				end
				ST_DUTY: begin
					if (duty_done)
						state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && out_free) begin
			res_status_q <= status_q;
			res_now_q    <= cur_q;
			res_goal_q   <= goal_q;
			res_duty_q   <= duty_val;
		end
	end

	svr_duty #(
		.MAX_ANGLE (MAX_ANGLE)
	) u_duty (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (duty_start_q),
		.angle     (cur_q),
		.min_pulse (min_pulse_q),
		.max_pulse (max_pulse_q),
		.duty_bits (duty_bits_q),
		.pwm_freq  (pwm_freq_q),
		.done      (duty_done),
		.duty      (duty_val)
	);

	assign res_valid  = res_valid_q;
	assign status     = res_status_q;
	assign angle_now  = res_now_q;
	assign angle_goal = res_goal_q;
	assign duty       = res_duty_q;

endmodule
